// File: rtl/core/ptdq_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// ptdq_pkg
// Shared types, sizes and constants of the periodic task dispatch queue.
// ============================================================================
package ptdq_pkg;

    localparam int QUEUE_DEPTH = 512;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int FILL_W      = 9;
    localparam int TASK_W      = 3;
    localparam int PERIOD_W    = 16;
    localparam int N_TIMERS    = 4;
    localparam int TIMER_W     = $clog2(N_TIMERS);
    localparam int CFG_IDX_W   = 8;

    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_ENQUEUE = 2'd1;
    localparam logic [1:0] CMD_DEQUEUE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_FAST_PERIOD    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEDIUM_PERIOD  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_PERIOD    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOWEST_PERIOD = 8'd3;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [TASK_W-1:0] task_number;
    } in_word_t;

    typedef struct packed {
        logic [TASK_W-1:0] task_out;
        logic              task_valid;
        logic              queue_empty;
        logic              queue_full;
        logic              overflow_seen;
        logic [FILL_W-1:0] fill_level;
    } out_word_t;

    typedef struct packed {
        logic               latch;
        logic               tick_step;
        logic               push_ext;
        logic               pop;
        logic               out_load;
        logic [TIMER_W-1:0] timer_idx;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

    function automatic logic [TASK_W-1:0] timer_task(input logic [TIMER_W-1:0] idx);
        case (idx)
            2'd0:    timer_task = 3'd2;
            2'd1:    timer_task = 3'd1;
            2'd2:    timer_task = 3'd3;
            default: timer_task = 3'd4;
        endcase
    endfunction

    function automatic logic [PERIOD_W-1:0] period_reset(input logic [TIMER_W-1:0] idx);
        case (idx)
            2'd0:    period_reset = 16'd5;
            2'd1:    period_reset = 16'd50;
            2'd2:    period_reset = 16'd100;
            default: period_reset = 16'd1000;
        endcase
    endfunction

endpackage

// File: rtl/core/ptdq_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// ptdq_ctrl
// Sequencer: accepts a word, steps the datapath through the command, then
// hands the result to the output register.
// ============================================================================
module ptdq_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           in_cmd,
    input  ptdq_pkg::dp_status_t status,
    output ptdq_pkg::dp_cmd_t    dp_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_TICK = 5'b00010,
        S_PUSH = 5'b00100,
        S_READ = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t                       state_reg, state_next;
    logic [ptdq_pkg::TIMER_W-1:0] idx_reg, idx_next;
    logic                         accept;
    logic                         last_timer;

    assign s_ready    = (state_reg == S_IDLE);
    assign accept     = s_valid && s_ready;
    assign last_timer = (idx_reg == ptdq_pkg::TIMER_W'(ptdq_pkg::N_TIMERS - 1));

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            S_IDLE: begin
                idx_next = '0;
                if (accept) begin
                    case (in_cmd)
                        ptdq_pkg::CMD_TICK:    state_next = S_TICK;
                        ptdq_pkg::CMD_ENQUEUE: state_next = S_PUSH;
                        ptdq_pkg::CMD_DEQUEUE: state_next = S_READ;
                        default:               state_next = S_DONE;
                    endcase
                end
            end
            S_TICK: begin
                idx_next = idx_reg + 1'b1;
                if (last_timer) begin
                    state_next = S_DONE;
                end
            end
            S_PUSH:  state_next = S_DONE;
            S_READ:  state_next = S_DONE;
            S_DONE: begin
                if (status.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        dp_cmd           = '0;
        dp_cmd.latch     = accept;
        dp_cmd.tick_step = (state_reg == S_TICK);
        dp_cmd.push_ext  = (state_reg == S_PUSH);
        dp_cmd.pop       = (state_reg == S_READ);
        dp_cmd.out_load  = (state_reg == S_DONE) && status.out_free;
        dp_cmd.timer_idx = idx_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

// File: rtl/core/ptdq_datapath.sv
`timescale 1ns / 1ps
// ============================================================================
// ptdq_datapath
// Task queue memory, pointers, tick counters, period registers and the
// result register.
// ============================================================================
module ptdq_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  ptdq_pkg::in_word_t               s_data,
    input  ptdq_pkg::dp_cmd_t                dp_cmd,
    output ptdq_pkg::dp_status_t             status,
    input  logic                             cfg_valid,
    input  logic [ptdq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ptdq_pkg::PERIOD_W-1:0]    cfg_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output ptdq_pkg::out_word_t              m_data
);

    localparam logic [ptdq_pkg::PTR_W-1:0] LAST_SLOT =
        ptdq_pkg::PTR_W'(ptdq_pkg::QUEUE_DEPTH - 1);

    logic [ptdq_pkg::TASK_W-1:0]   task_mem [ptdq_pkg::QUEUE_DEPTH];
    logic [ptdq_pkg::TASK_W-1:0]   rd_data_reg;
    logic [ptdq_pkg::TASK_W-1:0]   task_reg;
    logic [ptdq_pkg::PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [ptdq_pkg::PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [ptdq_pkg::PTR_W-1:0]    count_reg, count_next;
    logic                          dropped_reg;
    logic                          pop_ok_reg;
    logic [ptdq_pkg::PERIOD_W-1:0] period_reg  [ptdq_pkg::N_TIMERS];
    logic [ptdq_pkg::PERIOD_W-1:0] counter_reg [ptdq_pkg::N_TIMERS];
    logic [ptdq_pkg::PERIOD_W-1:0] cnt_dec;
    logic                          cnt_hit;
    logic                          full, empty;
    logic                          push_req, push_do, pop_do;
    logic [ptdq_pkg::TASK_W-1:0]   push_task;
    logic                          m_valid_reg;
    ptdq_pkg::out_word_t           out_reg;

    assign cnt_dec   = counter_reg[dp_cmd.timer_idx] - 1'b1;
    assign cnt_hit   = (cnt_dec == '0);
    assign full      = (count_reg == LAST_SLOT);
    assign empty     = (count_reg == '0);
    assign push_req  = (dp_cmd.tick_step && cnt_hit) || dp_cmd.push_ext;
    assign push_task = dp_cmd.tick_step ? ptdq_pkg::timer_task(dp_cmd.timer_idx) : task_reg;
    assign push_do   = push_req && !full;
    assign pop_do    = dp_cmd.pop && !empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_do) begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
            count_next  = count_reg + 1'b1;
        end else if (pop_do) begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
            count_next  = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_do) begin
            task_mem[wr_ptr_reg] <= push_task;
        end
        if (dp_cmd.pop) begin
            rd_data_reg <= task_mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.latch) begin
            task_reg   <= s_data.task_number;
            pop_ok_reg <= 1'b0;
        end else if (dp_cmd.pop) begin
            pop_ok_reg <= !empty;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg  <= '0;
            wr_ptr_reg  <= '0;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            for (int i = 0; i < ptdq_pkg::N_TIMERS; i++) begin
                period_reg[i]  <= ptdq_pkg::period_reset(ptdq_pkg::TIMER_W'(i));
                counter_reg[i] <= ptdq_pkg::period_reset(ptdq_pkg::TIMER_W'(i));
            end
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            if (push_req && full) begin
                dropped_reg <= 1'b1;
            end
            if (dp_cmd.tick_step) begin
                counter_reg[dp_cmd.timer_idx] <= cnt_hit ? period_reg[dp_cmd.timer_idx]
                                                         : cnt_dec;
            end
            if (cfg_valid && (cfg_index < ptdq_pkg::CFG_IDX_W'(ptdq_pkg::N_TIMERS))) begin
                period_reg[cfg_index[ptdq_pkg::TIMER_W-1:0]] <= cfg_data;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (dp_cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.out_load) begin
            out_reg.task_valid    <= pop_ok_reg;
            out_reg.task_out      <= pop_ok_reg ? rd_data_reg : '0;
            out_reg.queue_empty   <= empty;
            out_reg.queue_full    <= full;
            out_reg.overflow_seen <= dropped_reg;
            out_reg.fill_level    <= ptdq_pkg::FILL_W'(count_reg);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_data          = out_reg;
    assign status.out_free = !m_valid_reg || m_ready;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= LAST_SLOT)
        else $error("queue fill beyond capacity");

    a_dropped_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        dropped_reg |=> dropped_reg)
        else $error("overflow flag cleared");

    a_empty_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (dp_cmd.pop && empty) |=> ($stable(rd_ptr_reg) && !pop_ok_reg))
        else $error("pop from empty queue moved the read pointer");

    a_one_op: assert property (@(posedge aclk) disable iff (!aresetn)
        !(dp_cmd.pop && (dp_cmd.tick_step || dp_cmd.push_ext)))
        else $error("push and pop issued together");

endmodule

// File: rtl/core/periodic_task_dispatch_queue_core.sv
`timescale 1ns / 1ps
// ============================================================================
// periodic_task_dispatch_queue_core
// Task queue fed by four periodic tick counters and external enqueues.
// ============================================================================
// Usage:
//   s_valid/s_ready/s_data carry one command word: tick, enqueue of
//   s_data.task_number, or dequeue of the oldest task. Every word gives
//   exactly one result word on m_valid/m_ready/m_data, holding the dequeued
//   task (if any) and the queue status after the command.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the four period registers
//   (index 0 fast .. 3 slowest); other indexes are ignored. cfg_ready is
//   always high; write only while no command is in flight.
//   A tick steps the four counters in turn (one counter per cycle, since
//   the queue memory takes one write per cycle); enqueue pushes and
//   dequeue pops before the result goes to the output register. One word
//   is in work at a time: s_ready stays low until its result is loaded.
//   Reset (aresetn low, synchronous) empties the queue, clears the overflow
//   flag and loads periods and counters with 5, 50, 100 and 1000.
//   A stalled receiver holds the result; the next word may be accepted
//   meanwhile, and its result waits until the output register frees up.
// ============================================================================
module periodic_task_dispatch_queue_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  ptdq_pkg::in_word_t             s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output ptdq_pkg::out_word_t            m_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ptdq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ptdq_pkg::PERIOD_W-1:0]  cfg_data
);

    ptdq_pkg::dp_cmd_t    dp_cmd;
    ptdq_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    ptdq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .in_cmd  (s_data.cmd),
        .status  (status),
        .dp_cmd  (dp_cmd)
    );

    ptdq_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .dp_cmd    (dp_cmd),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Testbench of the periodic task dispatch queue core. A driver feeds command
// words from a backlog, a monitor predicts each result word on acceptance and
// compares it field by field. Phases change the period registers and the
// idling of both channels, fill the queue to overflow, drain it past empty
// and hold off the receiver until the input stalls.
// ============================================================================
module tb_top;

    localparam logic [1:0] CMD_RESERVED = 2'd3;
    localparam logic [ptdq_pkg::CFG_IDX_W-1:0] REG_NONE_LOW = 8'd4;
    localparam logic [ptdq_pkg::CFG_IDX_W-1:0] REG_NONE_TOP = 8'hFF;
    localparam logic [ptdq_pkg::N_TIMERS-1:0][ptdq_pkg::TASK_W-1:0] TIMER_TASK_NO =
        {3'd4, 3'd3, 3'd1, 3'd2};
    localparam logic [ptdq_pkg::N_TIMERS-1:0][ptdq_pkg::PERIOD_W-1:0] PERIOD_AT_RESET =
        {16'd1000, 16'd100, 16'd50, 16'd5};
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 16;

    logic                           aclk;
    logic                           aresetn   = 1'b0;
    logic                           s_valid   = 1'b0;
    logic                           s_ready;
    ptdq_pkg::in_word_t             s_data    = '0;
    logic                           m_valid;
    logic                           m_ready   = 1'b0;
    ptdq_pkg::out_word_t            m_data;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [ptdq_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [ptdq_pkg::PERIOD_W-1:0]  cfg_data  = '0;

    ptdq_pkg::in_word_t             cmd_backlog [$];
    ptdq_pkg::out_word_t            due_results [$];
    logic [ptdq_pkg::TASK_W-1:0]    model_tasks [$];
    logic [ptdq_pkg::PERIOD_W-1:0]  model_timer [ptdq_pkg::N_TIMERS];
    logic [ptdq_pkg::PERIOD_W-1:0]  model_period [ptdq_pkg::N_TIMERS];
    logic                           model_dropped;

    int  words_queued   = 0;
    int  words_done     = 0;
    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    int  hold_requests  = 0;
    int  hold_seen      = 0;
    int  hold_left      = 0;
    int  quiet_cycles   = 0;
    bit  s_took         = 1'b0;
    bit  mismatch_seen  = 1'b0;

    periodic_task_dispatch_queue_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic void reset_model();
        model_tasks.delete();
        model_dropped = 1'b0;
        for (int i = 0; i < ptdq_pkg::N_TIMERS; i++) begin
            model_period[i] = PERIOD_AT_RESET[i];
            model_timer[i]  = PERIOD_AT_RESET[i];
        end
    endfunction

    function automatic void push_model(input logic [ptdq_pkg::TASK_W-1:0] task_no);
        if (model_tasks.size() >= ptdq_pkg::QUEUE_DEPTH - 1) begin
            model_dropped = 1'b1;
        end else begin
            model_tasks.push_back(task_no);
        end
    endfunction

    function automatic ptdq_pkg::out_word_t predict_dispatch(input ptdq_pkg::in_word_t w);
        ptdq_pkg::out_word_t r;
        r = '0;
        case (w.cmd)
            ptdq_pkg::CMD_TICK: begin
                for (int i = 0; i < ptdq_pkg::N_TIMERS; i++) begin
                    model_timer[i] = model_timer[i] - 1'b1;
                    if (model_timer[i] == '0) begin
                        model_timer[i] = model_period[i];
                        push_model(TIMER_TASK_NO[i]);
                    end
                end
            end
            ptdq_pkg::CMD_ENQUEUE: begin
                push_model(w.task_number);
            end
            ptdq_pkg::CMD_DEQUEUE: begin
                if (model_tasks.size() != 0) begin
                    r.task_out   = model_tasks.pop_front();
                    r.task_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase
        r.queue_empty   = (model_tasks.size() == 0);
        r.queue_full    = (model_tasks.size() == ptdq_pkg::QUEUE_DEPTH - 1);
        r.overflow_seen = model_dropped;
        r.fill_level    = ptdq_pkg::FILL_W'(model_tasks.size());
        return r;
    endfunction

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, want, got);
            mismatch_seen = 1'b1;
        end
    endtask

    // driver: advance to the next word once the current one is taken
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_took) begin
            if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_data  <= cmd_backlog.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, or a long hold when one is requested
    always @(negedge aclk) begin
        if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin : result_monitor
        ptdq_pkg::out_word_t want;
        s_took = s_valid && s_ready;
        if (aresetn) begin
            if (cfg_valid && cfg_ready && cfg_index < ptdq_pkg::N_TIMERS) begin
                model_period[cfg_index[ptdq_pkg::TIMER_W-1:0]] = cfg_data;
            end
            if (m_valid && m_ready) begin
                words_done = words_done + 1;
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, actual %h",
                             $time, m_data);
                    mismatch_seen = 1'b1;
                end else begin
                    want = due_results.pop_front();
                    check_field("task_out", want.task_out, m_data.task_out);
                    check_field("task_valid", want.task_valid, m_data.task_valid);
                    check_field("queue_empty", want.queue_empty, m_data.queue_empty);
                    check_field("queue_full", want.queue_full, m_data.queue_full);
                    check_field("overflow_seen", want.overflow_seen,
                                m_data.overflow_seen);
                    check_field("fill_level", want.fill_level, m_data.fill_level);
                end
            end
            if (s_took) begin
                due_results.push_back(predict_dispatch(s_data));
            end
            if (s_took || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles = quiet_cycles + 1;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("periodic_task_dispatch_queue_core regression: fail");
                    $finish;
                end
            end
        end
    end

    task automatic queue_word(input logic [1:0] cmd,
                              input logic [ptdq_pkg::TASK_W-1:0] num);
        ptdq_pkg::in_word_t w;
        w.cmd         = cmd;
        w.task_number = num;
        cmd_backlog.push_back(w);
        words_queued = words_queued + 1;
    endtask

    task automatic queue_burst(input int count, input int fill_pct, input int tick_pct);
        int roll;
        repeat (count) begin
            roll = $urandom_range(99);
            if (roll < 3) begin
                queue_word(CMD_RESERVED, ptdq_pkg::TASK_W'($urandom_range(7)));
            end else if (roll < fill_pct && $urandom_range(99) < tick_pct) begin
                queue_word(ptdq_pkg::CMD_TICK, ptdq_pkg::TASK_W'($urandom_range(7)));
            end else if (roll < fill_pct) begin
                queue_word(ptdq_pkg::CMD_ENQUEUE, ptdq_pkg::TASK_W'($urandom_range(7)));
            end else begin
                queue_word(ptdq_pkg::CMD_DEQUEUE, ptdq_pkg::TASK_W'($urandom_range(7)));
            end
        end
    endtask

    task automatic queue_mixed(input int count);
        int len;
        int bias;
        while (count > 0) begin
            len = $urandom_range(80, 10);
            if (len > count) len = count;
            case ($urandom_range(2))
                0:       bias = 15;
                1:       bias = 50;
                default: bias = 85;
            endcase
            queue_burst(len, bias, 70);
            count = count - len;
        end
    endtask

    task automatic wait_drained();
        do @(negedge aclk); while (words_done != words_queued);
    endtask

    task automatic write_reg(input logic [ptdq_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ptdq_pkg::PERIOD_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic set_periods(input logic [ptdq_pkg::PERIOD_W-1:0] fast,
                               input logic [ptdq_pkg::PERIOD_W-1:0] mid,
                               input logic [ptdq_pkg::PERIOD_W-1:0] slow,
                               input logic [ptdq_pkg::PERIOD_W-1:0] slowest);
        write_reg(ptdq_pkg::REG_FAST_PERIOD, fast);
        write_reg(ptdq_pkg::REG_MEDIUM_PERIOD, mid);
        write_reg(ptdq_pkg::REG_SLOW_PERIOD, slow);
        write_reg(ptdq_pkg::REG_SLOWEST_PERIOD, slowest);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic start_phase(input int idle_pct, input int stall_pct);
        @(posedge aclk);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
    endtask

    initial begin
        reset_model();
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        start_phase(0, 0);
        queue_word(ptdq_pkg::CMD_DEQUEUE, 3'd7);
        queue_word(CMD_RESERVED, 3'd5);
        queue_word(ptdq_pkg::CMD_ENQUEUE, 3'd0);
        queue_word(ptdq_pkg::CMD_ENQUEUE, 3'd7);
        queue_word(ptdq_pkg::CMD_ENQUEUE, 3'd5);
        repeat (3) queue_word(ptdq_pkg::CMD_TICK, 3'd7);
        repeat (2) queue_word(ptdq_pkg::CMD_TICK, 3'd0);
        repeat (5) queue_word(ptdq_pkg::CMD_DEQUEUE, 3'd0);
        wait_drained();

        // fill past capacity with every period set to 1
        write_reg(REG_NONE_LOW, 16'hFFFF);
        write_reg(REG_NONE_TOP, 16'h0000);
        set_periods(16'd1, 16'd1, 16'd1, 16'd1);
        start_phase(0, 0);
        queue_burst(850, 97, 97);
        wait_drained();

        // drain past empty; medium period wraps, fast and slowest at the top
        set_periods(16'hFFFF, 16'd0, 16'd40000, 16'hFFFF);
        start_phase(53, 0);
        queue_burst(560, 3, 50);
        queue_burst(60, 80, 80);
        wait_drained();

        set_periods(16'd3, 16'd7, 16'd11, 16'd2);
        start_phase(0, 53);
        queue_mixed(160);
        wait_drained();

        set_periods(16'd1, 16'hFFFF, 16'd0, 16'd1);
        start_phase(7, 7);
        queue_mixed(120);
        wait_drained();

        // hold the receiver while words keep coming, then run a second burst
        set_periods(16'd5, 16'd50, 16'd100, 16'd1000);
        start_phase(0, 0);
        hold_requests = hold_requests + 1;
        queue_burst(100, 95, 95);
        wait_drained();
        start_phase(0, 0);
        queue_burst(60, 90, 90);
        wait_drained();

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (!mismatch_seen && due_results.size() == 0) begin
            $display("periodic_task_dispatch_queue_core regression: pass");
        end else begin
            $display("periodic_task_dispatch_queue_core regression: fail");
        end
        $finish;
    end

endmodule
